FILE: design/ppsc_pkg.sv
// Package for the pure-pursuit steering core: widths, register indexes,
// the arctangent table used by the angle iterations, and small helpers.
// Depends on nothing.
`timescale 1ns / 1ps
package ppsc_pkg;

   localparam int COORD_WIDTH  = 24;
   localparam int PROD_WIDTH   = 2 * COORD_WIDTH;
   localparam int BISECT_STEPS = COORD_WIDTH + 2;
   localparam int CORDIC_STEPS = 23;
   localparam int CNT_WIDTH    = 5;
   localparam int ANGLE_WIDTH  = 25;
   localparam int DEG90_Q16    = 5898240;

   localparam logic [2:0] CSR_LOOKAHEAD = 3'd0;
   localparam logic [2:0] CSR_WHEELBASE = 3'd1;
   localparam logic [2:0] CSR_MAX_TURN  = 3'd2;
   localparam logic [2:0] CSR_OFFSET    = 3'd3;
   localparam logic [2:0] CSR_SPEED     = 3'd4;

   localparam logic [1:0] CASE_CROSSING = 2'd0;
   localparam logic [1:0] CASE_FIRST    = 2'd1;
   localparam logic [1:0] CASE_LAST     = 2'd2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [PROD_WIDTH-1:0] prod_type;

   // Magnitude of a signed coordinate; the most negative value maps to 2^(W-1).
   function automatic logic [COORD_WIDTH-1:0] coord_mag(input coord_type v);
      coord_type neg;
      neg = -v;
      return v[COORD_WIDTH-1] ? neg : v;
   endfunction

   // Arctangent of 2^-i in degrees, Q16.
   function automatic logic [22:0] atan_deg(input logic [CNT_WIDTH-1:0] i);
      logic [22:0] r;
      case (i)
         5'd0:  r = 23'd2949120;
         5'd1:  r = 23'd1740967;
         5'd2:  r = 23'd919879;
         5'd3:  r = 23'd466945;
         5'd4:  r = 23'd234379;
         5'd5:  r = 23'd117304;
         5'd6:  r = 23'd58666;
         5'd7:  r = 23'd29335;
         5'd8:  r = 23'd14668;
         5'd9:  r = 23'd7334;
         5'd10: r = 23'd3667;
         5'd11: r = 23'd1833;
         5'd12: r = 23'd917;
         5'd13: r = 23'd458;
         5'd14: r = 23'd229;
         5'd15: r = 23'd115;
         5'd16: r = 23'd57;
         5'd17: r = 23'd29;
         5'd18: r = 23'd14;
         5'd19: r = 23'd7;
         5'd20: r = 23'd4;
         5'd21: r = 23'd2;
         5'd22: r = 23'd1;
         default: r = 23'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: design/pure_pursuit_steering_core.sv
// Pure-pursuit steering core. One path point per transaction, one point in flight at a time.
// A plain point runs the radius square, its own square, evaluation and finish before the core
// takes the next one. The point that first leaves the circle adds bisection (26 steps, each a
// midpoint square on the shared multiplier and an update). The last point adds squaring,
// normalization, the angle iterations and 17 divide steps, less when it saturates.
// Synchronous active-high reset restores the register defaults and plan state.
`timescale 1ns / 1ps
module pure_pursuit_steering_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [ppsc_pkg::COORD_WIDTH-1:0] req_point_x,
   input  logic signed [ppsc_pkg::COORD_WIDTH-1:0] req_point_y,
   input  logic        req_last_point,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_steering_ratio,
   output logic [15:0] rsp_speed,
   output logic signed [ppsc_pkg::COORD_WIDTH-1:0] rsp_goal_x,
   output logic signed [ppsc_pkg::COORD_WIDTH-1:0] rsp_goal_y,
   output logic [1:0]  rsp_goal_case,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   import ppsc_pkg::*;

   // Sequencer states. The squaring steps form a small subroutine that
   // returns to the state held in ret_ff.
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_L2A   = 5'd1;
   localparam logic [4:0] S_L2B   = 5'd2;
   localparam logic [4:0] S_SQ0   = 5'd3;
   localparam logic [4:0] S_SQ1   = 5'd4;
   localparam logic [4:0] S_SQ2   = 5'd5;
   localparam logic [4:0] S_EVAL  = 5'd6;
   localparam logic [4:0] S_BIS   = 5'd7;
   localparam logic [4:0] S_BUPD  = 5'd8;
   localparam logic [4:0] S_FIN   = 5'd9;
   localparam logic [4:0] S_NUM   = 5'd10;
   localparam logic [4:0] S_NUM2  = 5'd11;
   localparam logic [4:0] S_NORM  = 5'd12;
   localparam logic [4:0] S_CORD  = 5'd13;
   localparam logic [4:0] S_RATIO = 5'd14;
   localparam logic [4:0] S_DIV   = 5'd15;
   localparam logic [4:0] S_DONE  = 5'd16;
   localparam logic [4:0] S_OUT   = 5'd17;

   localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   // Configuration registers.
   logic [22:0] rad_ff, wb_ff;
   logic [14:0] mt_ff;
   logic [23:0] off_ff;
   logic [15:0] spd_ff;

   // Sequencer and datapath registers.
   logic [4:0] state_ff, state_in, ret_ff, ret_in;
   coord_type cx_ff, cx_in, cy_ff, cy_in;
   logic last_ff, last_in;
   prod_type l2_ff, l2_in, acc_ff, acc_in;
   coord_type opa_ff, opa_in, opb_ff, opb_in;
   logic awaiting_ff, awaiting_in, fout_ff, fout_in, found_ff, found_in;
   logic cur_in_ff, cur_in_in;
   coord_type fgx_ff, fgx_in, fgy_ff, fgy_in, px_ff, px_in, py_ff, py_in;
   coord_type crx_ff, crx_in, cry_ff, cry_in;
   coord_type ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   coord_type gx_ff, gx_in, gy_ff, gy_in;
   logic [1:0] gcase_ff, gcase_in;
   prod_type den_ff, den_in, num_ff, num_in;
   logic signed [32:0] cox_ff, cox_in, coy_ff, coy_in;
   logic signed [ANGLE_WIDTH-1:0] z_ff, z_in;
   logic [40:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic [16:0] q_ff, q_in;
   logic [15:0] res_ff, res_in;

   // Output registers.
   logic rv_ff, rv_in;
   logic [15:0] o_ratio_ff, o_ratio_in, o_speed_ff, o_speed_in;
   coord_type o_gx_ff, o_gx_in, o_gy_ff, o_gy_in;
   logic [1:0] o_case_ff, o_case_in;

   // Shared multiplier.
   logic [COORD_WIDTH-1:0] mul_a, mul_b;
   prod_type prod;

   // Combinational helpers.
   logic signed [COORD_WIDTH:0] xsum, midx_s, midy_s;
   coord_type xsat, midx, midy, selx, sely;
   logic [1:0] selcase;
   logic in_circle;
   logic signed [32:0] xs, ys;
   logic signed [ANGLE_WIDTH-1:0] zclamp, step_ang;
   logic [22:0] m16;
   logic signed [25:0] nval;
   logic [23:0] div2m;

   ppsc_mult u_mult (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   // Rear-axle x: lidar x plus the sensor offset, saturated to the coordinate range.
   assign xsum = {req_point_x[COORD_WIDTH-1], req_point_x} + {off_ff[23], off_ff};
   assign xsat = (xsum[COORD_WIDTH] != xsum[COORD_WIDTH-1]) ?
                 (xsum[COORD_WIDTH] ? CMIN : CMAX) : xsum[COORD_WIDTH-1:0];

   // Bisection midpoint: floor of half the sum on each axis.
   assign midx_s = {ax_ff[COORD_WIDTH-1], ax_ff} + {bx_ff[COORD_WIDTH-1], bx_ff};
   assign midy_s = {ay_ff[COORD_WIDTH-1], ay_ff} + {by_ff[COORD_WIDTH-1], by_ff};
   assign midx = midx_s[COORD_WIDTH:1];
   assign midy = midy_s[COORD_WIDTH:1];

   assign in_circle = (acc_ff <= l2_ff);

   // Goal choice at the end of a plan.
   always_comb begin
      if (fout_ff) begin
         selx = fgx_ff; sely = fgy_ff; selcase = CASE_FIRST;
      end else if (cur_in_ff) begin
         selx = cx_ff; sely = cy_ff; selcase = CASE_LAST;
      end else begin
         selx = crx_ff; sely = cry_ff; selcase = CASE_CROSSING;
      end
   end

   assign xs = cox_ff >>> cnt_ff;
   assign ys = coy_ff >>> cnt_ff;
   assign step_ang = {2'b00, atan_deg(cnt_ff)};
   assign zclamp = z_ff[ANGLE_WIDTH-1] ? '0 :
                   ((z_ff > ANGLE_WIDTH'(DEG90_Q16)) ? ANGLE_WIDTH'(DEG90_Q16) : z_ff);

   assign m16 = {mt_ff, 8'd0};
   assign nval = {3'b000, m16} - {z_ff[ANGLE_WIDTH-1], z_ff};
   assign div2m = {m16, 1'b0};

   // Multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_L2A: begin
            mul_a = {1'b0, rad_ff};
            mul_b = {1'b0, rad_ff};
         end
         S_SQ0: begin
            mul_a = coord_mag(opa_ff);
            mul_b = coord_mag(opa_ff);
         end
         S_SQ1: begin
            mul_a = coord_mag(opb_ff);
            mul_b = coord_mag(opb_ff);
         end
         S_NUM: begin
            mul_a = {1'b0, wb_ff};
            mul_b = coord_mag(gy_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff; ret_in = ret_ff;
      cx_in = cx_ff; cy_in = cy_ff; last_in = last_ff;
      l2_in = l2_ff; acc_in = acc_ff; opa_in = opa_ff; opb_in = opb_ff;
      awaiting_in = awaiting_ff; fout_in = fout_ff; found_in = found_ff;
      cur_in_in = cur_in_ff;
      fgx_in = fgx_ff; fgy_in = fgy_ff; px_in = px_ff; py_in = py_ff;
      crx_in = crx_ff; cry_in = cry_ff;
      ax_in = ax_ff; ay_in = ay_ff; bx_in = bx_ff; by_in = by_ff;
      cnt_in = cnt_ff; gx_in = gx_ff; gy_in = gy_ff; gcase_in = gcase_ff;
      den_in = den_ff; num_in = num_ff; cox_in = cox_ff; coy_in = coy_ff;
      z_in = z_ff; rem_in = rem_ff; dsh_in = dsh_ff; q_in = q_ff; res_in = res_ff;
      rv_in = rv_ff && !rsp_ready;
      o_ratio_in = o_ratio_ff; o_speed_in = o_speed_ff;
      o_gx_in = o_gx_ff; o_gy_in = o_gy_ff; o_case_in = o_case_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cx_in = xsat; cy_in = req_point_y; last_in = req_last_point;
               opa_in = xsat; opb_in = req_point_y;
               state_in = S_L2A;
            end
         end
         S_L2A: state_in = S_L2B;
         S_L2B: begin
            l2_in = prod;
            ret_in = S_EVAL;
            state_in = S_SQ0;
         end
         S_SQ0: state_in = S_SQ1;
         S_SQ1: begin
            acc_in = prod;
            state_in = S_SQ2;
         end
         S_SQ2: begin
            acc_in = acc_ff + prod;
            state_in = ret_ff;
         end
         S_EVAL: begin
            cur_in_in = in_circle;
            px_in = cx_ff; py_in = cy_ff;
            state_in = S_FIN;
            if (awaiting_ff) begin
               awaiting_in = 1'b0;
               fout_in = (acc_ff >= l2_ff);
               found_in = 1'b0;
               fgx_in = cx_ff; fgy_in = cy_ff;
            end else if (!fout_ff && !found_ff && !in_circle) begin
               ax_in = px_ff; ay_in = py_ff; bx_in = cx_ff; by_in = cy_ff;
               cnt_in = '0;
               state_in = S_BIS;
            end
         end
         S_BIS: begin
            opa_in = midx; opb_in = midy;
            ret_in = S_BUPD;
            state_in = S_SQ0;
         end
         S_BUPD: begin
            if (in_circle) begin
               ax_in = opa_ff; ay_in = opb_ff;
            end else begin
               bx_in = opa_ff; by_in = opb_ff;
            end
            if (cnt_ff == CNT_WIDTH'(BISECT_STEPS - 1)) begin
               crx_in = in_circle ? opa_ff : ax_ff;
               cry_in = in_circle ? opb_ff : ay_ff;
               found_in = 1'b1;
               state_in = S_FIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               state_in = S_BIS;
            end
         end
         S_FIN: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else begin
               gx_in = selx; gy_in = sely; gcase_in = selcase;
               opa_in = selx; opb_in = sely;
               awaiting_in = 1'b1; fout_in = 1'b0; found_in = 1'b0;
               ret_in = S_NUM;
               state_in = S_SQ0;
            end
         end
         S_NUM: begin
            den_in = acc_ff;
            state_in = S_NUM2;
         end
         S_NUM2: begin
            num_in = {prod[PROD_WIDTH-2:0], 1'b0};
            state_in = S_NORM;
         end
         S_NORM: begin
            if (den_ff == '0 || num_ff == '0) begin
               z_in = '0;
               state_in = S_RATIO;
            end else if (num_ff[PROD_WIDTH-1:30] != '0 || den_ff[PROD_WIDTH-1:30] != '0) begin
               num_in = num_ff >> 1;
               den_in = den_ff >> 1;
            end else if (!num_ff[29] && !den_ff[29]) begin
               num_in = num_ff << 1;
               den_in = den_ff << 1;
            end else begin
               cox_in = {3'b000, den_ff[29:0]};
               coy_in = {3'b000, num_ff[29:0]};
               z_in = '0;
               cnt_in = '0;
               state_in = S_CORD;
            end
         end
         S_CORD: begin
            if (coy_ff == '0 || cnt_ff == CNT_WIDTH'(CORDIC_STEPS)) begin
               z_in = gy_ff[COORD_WIDTH-1] ? -zclamp : zclamp;
               state_in = S_RATIO;
            end else begin
               if (!coy_ff[32]) begin
                  cox_in = cox_ff + ys;
                  coy_in = coy_ff - xs;
                  z_in = z_ff + step_ang;
               end else begin
                  cox_in = cox_ff - ys;
                  coy_in = coy_ff + xs;
                  z_in = z_ff - step_ang;
               end
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_RATIO: begin
            state_in = S_OUT;
            if (m16 == '0) begin
               if (z_ff > 0) res_in = 16'd0;
               else if (z_ff < 0) res_in = 16'hFFFF;
               else res_in = 16'h8000;
            end else if (nval <= 0) begin
               res_in = 16'd0;
            end else if (nval >= $signed({2'b00, div2m})) begin
               res_in = 16'hFFFF;
            end else begin
               // Rounded quotient (n * 2^16 + M) / (2M) by restoring division.
               rem_in = {1'b0, nval[23:0], 16'd0} + {18'd0, m16};
               dsh_in = {1'b0, div2m, 16'd0};
               q_in = '0;
               cnt_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               q_in = {q_ff[15:0], 1'b1};
            end else begin
               q_in = {q_ff[15:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(16)) state_in = S_DONE;
         end
         S_DONE: begin
            res_in = q_ff[16] ? 16'hFFFF : q_ff[15:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            // The output register frees the sequencer once the slot is open.
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               o_ratio_in = res_ff;
               o_speed_in = spd_ff;
               o_gx_in = gx_ff;
               o_gy_in = gy_ff;
               o_case_in = gcase_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         awaiting_ff <= 1'b1;
         fout_ff <= 1'b0;
         found_ff <= 1'b0;
         rv_ff <= 1'b0;
         rad_ff <= 23'd65536;
         wb_ff <= 23'd21299;
         mt_ff <= 15'd8704;
         off_ff <= 24'd0;
         spd_ff <= 16'd13107;
      end else begin
         state_ff <= state_in;
         awaiting_ff <= awaiting_in;
         fout_ff <= fout_in;
         found_ff <= found_in;
         rv_ff <= rv_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_LOOKAHEAD: rad_ff <= csr_data[22:0];
               CSR_WHEELBASE: wb_ff <= csr_data[22:0];
               CSR_MAX_TURN:  mt_ff <= csr_data[14:0];
               CSR_OFFSET:    off_ff <= csr_data;
               CSR_SPEED:     spd_ff <= csr_data[15:0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      ret_ff <= ret_in;
      cx_ff <= cx_in; cy_ff <= cy_in; last_ff <= last_in;
      l2_ff <= l2_in; acc_ff <= acc_in; opa_ff <= opa_in; opb_ff <= opb_in;
      cur_in_ff <= cur_in_in;
      fgx_ff <= fgx_in; fgy_ff <= fgy_in; px_ff <= px_in; py_ff <= py_in;
      crx_ff <= crx_in; cry_ff <= cry_in;
      ax_ff <= ax_in; ay_ff <= ay_in; bx_ff <= bx_in; by_ff <= by_in;
      cnt_ff <= cnt_in; gx_ff <= gx_in; gy_ff <= gy_in; gcase_ff <= gcase_in;
      den_ff <= den_in; num_ff <= num_in; cox_ff <= cox_in; coy_ff <= coy_in;
      z_ff <= z_in; rem_ff <= rem_in; dsh_ff <= dsh_in; q_ff <= q_in; res_ff <= res_in;
      o_ratio_ff <= o_ratio_in; o_speed_ff <= o_speed_in;
      o_gx_ff <= o_gx_in; o_gy_ff <= o_gy_in; o_case_ff <= o_case_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_steering_ratio = o_ratio_ff;
   assign rsp_speed = o_speed_ff;
   assign rsp_goal_x = o_gx_ff;
   assign rsp_goal_y = o_gy_ff;
   assign rsp_goal_case = o_case_ff;

endmodule

FILE: design/ppsc_mult.sv
// Shared unsigned multiplier with a registered product.
// Depends on ppsc_pkg.
`timescale 1ns / 1ps
module ppsc_mult (
   input  logic                            clock,
   input  logic [ppsc_pkg::COORD_WIDTH-1:0] mul_a,
   input  logic [ppsc_pkg::COORD_WIDTH-1:0] mul_b,
   output ppsc_pkg::prod_type              prod
);
   import ppsc_pkg::*;

   prod_type prod_ff;
   prod_type prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

FILE: design/ppsc_checker.sv
// Port-level checks for the pure-pursuit steering core, bound to the top level.
// Depends on ppsc_pkg and pure_pursuit_steering_core.
`timescale 1ns / 1ps
module ppsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_goal_case,
   input logic [15:0] rsp_steering_ratio
);
   import ppsc_pkg::*;

   a_ready_after_reset: assert property (@(posedge clock) reset |=> req_ready)
      else $error("core not ready after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("core took a second transaction while busy");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared one cycle after a transaction");

   a_case_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_goal_case == CASE_CROSSING || rsp_goal_case == CASE_FIRST ||
                     rsp_goal_case == CASE_LAST))
      else $error("illegal goal case");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_steering_ratio))
      else $error("stalled result changed");

endmodule

bind pure_pursuit_steering_core ppsc_checker u_ppsc_checker (.*);
